// File: rtl/nrtp_pkg.sv
`default_nettype none

package nrtp_pkg;

	localparam int FIELD_LIMIT = 16;
	localparam int CNT_W       = $clog2(FIELD_LIMIT + 1);

	localparam logic [7:0] CH_DOLLAR      = 8'h24;
	localparam logic [7:0] CH_STAR        = 8'h2A;
	localparam logic [7:0] CH_COMMA       = 8'h2C;
	localparam logic [7:0] CH_A           = 8'h41;
	localparam logic [7:0] CH_G           = 8'h47;
	localparam logic [7:0] CH_P           = 8'h50;
	localparam logic [7:0] CH_R           = 8'h52;
	localparam logic [7:0] CH_M           = 8'h4D;
	localparam logic [7:0] CH_C           = 8'h43;
	localparam logic [7:0] HEX_DIGIT_MAX  = 8'h39;
	localparam logic [7:0] HEX_ALPHA_BIAS = 8'h37;

	localparam logic [3:0] CODE_ONE   = 4'd1;
	localparam logic [3:0] CODE_BLANK = 4'd10;

	localparam int RES_W   = 17;
	localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_HDR_G,
		ST_HDR_P,
		ST_HDR_R,
		ST_HDR_M,
		ST_HDR_C,
		ST_COMMA,
		ST_TIME,
		ST_VALID,
		ST_SKIP,
		ST_CK_HI,
		ST_CK_LO
	} step_t;

	typedef struct packed {
		logic       no_fix;
		logic [3:0] ones_minute;
		logic [3:0] tens_minute;
		logic [3:0] ones_hour;
		logic [3:0] tens_hour_code;
	} result_t;

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} hour_t;

	function automatic logic [3:0] hex_nibble(logic [7:0] b);
		logic [7:0] v;
		v = (b > HEX_DIGIT_MAX) ? (b - HEX_ALPHA_BIAS) : b;
		return v[3:0];
	endfunction

	// UTC hour folded to 12-hour form, then shifted back by the offset
	function automatic hour_t to_local_hour(logic [3:0] n0, logic [3:0] n1, logic [3:0] tz);
		logic [7:0] h;
		logic [8:0] d;
		logic [8:0] e;
		hour_t      r;
		h = ({4'b0, n0} << 3) + ({4'b0, n0} << 1) + {4'b0, n1};
		if (h > 8'd12) h = h - 8'd12;
		if (h <= {4'b0, tz}) h = h + 8'd12;
		d = {1'b0, h} - {5'b0, tz};
		if (d[8] || (d[7:0] > 8'd9)) begin
			r.tens = 4'd1;
			e      = d - 9'd10;
		end else begin
			r.tens = 4'd0;
			e      = d;
		end
		r.ones = e[3:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/nrtp_core.sv
`default_nettype none

module nrtp_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [7:0]        rx_byte,
	input  wire logic [3:0]        tz_offset,
	output logic                   res_valid,
	output nrtp_pkg::result_t      res
);

	nrtp_pkg::step_t               step_q, step_d;
	logic [nrtp_pkg::CNT_W-1:0]    cnt_q, cnt_d;
	logic [7:0]                    run_xor_q, run_xor_d;
	logic [7:0]                    saved_xor_q, saved_xor_d;
	logic [7:0]                    recv_xor_q, recv_xor_d;
	logic                          fix_valid_q, fix_valid_d;
	logic [3:0]                    nib_q [4];
	logic [3:0]                    nib_d [4];
	nrtp_pkg::hour_t               hour;
	logic [7:0]                    recv_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= nrtp_pkg::ST_HUNT;
			cnt_q       <= '0;
			run_xor_q   <= '0;
			saved_xor_q <= '0;
			recv_xor_q  <= '0;
			fix_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				nib_q[i] <= '0;
			end
		end else if (en) begin
			step_q      <= step_d;
			cnt_q       <= cnt_d;
			run_xor_q   <= run_xor_d;
			saved_xor_q <= saved_xor_d;
			recv_xor_q  <= recv_xor_d;
			fix_valid_q <= fix_valid_d;
			for (int i = 0; i < 4; i++) begin
				nib_q[i] <= nib_d[i];
			end
		end
	end

	assign hour      = nrtp_pkg::to_local_hour(nib_q[0], nib_q[1], tz_offset);
	assign recv_full = {recv_xor_q[7:4], nrtp_pkg::hex_nibble(rx_byte)};

	always_comb begin
		step_d      = step_q;
		cnt_d       = cnt_q;
		saved_xor_d = saved_xor_q;
		recv_xor_d  = recv_xor_q;
		fix_valid_d = fix_valid_q;
		for (int i = 0; i < 4; i++) begin
			nib_d[i] = nib_q[i];
		end
		res_valid          = 1'b0;
		res.tens_hour_code = (nib_q[0] == 4'd1) ? nrtp_pkg::CODE_ONE : nrtp_pkg::CODE_BLANK;
		res.ones_hour      = nib_q[1];
		res.tens_minute    = nib_q[2];
		res.ones_minute    = nib_q[3];
		res.no_fix         = ~fix_valid_q;

		run_xor_d = (rx_byte != nrtp_pkg::CH_STAR) ? (run_xor_q ^ rx_byte) : run_xor_q;

		unique case (step_q)
			nrtp_pkg::ST_HUNT: begin
				step_d    = (rx_byte == nrtp_pkg::CH_DOLLAR) ? nrtp_pkg::ST_HDR_G
					: nrtp_pkg::ST_HUNT;
				run_xor_d = '0;
			end
			nrtp_pkg::ST_HDR_G: begin
				step_d = (rx_byte == nrtp_pkg::CH_G) ? nrtp_pkg::ST_HDR_P : nrtp_pkg::ST_HUNT;
			end
			nrtp_pkg::ST_HDR_P: begin
				step_d = (rx_byte == nrtp_pkg::CH_P) ? nrtp_pkg::ST_HDR_R : nrtp_pkg::ST_HUNT;
			end
			nrtp_pkg::ST_HDR_R: begin
				step_d = (rx_byte == nrtp_pkg::CH_R) ? nrtp_pkg::ST_HDR_M : nrtp_pkg::ST_HUNT;
			end
			nrtp_pkg::ST_HDR_M: begin
				step_d = (rx_byte == nrtp_pkg::CH_M) ? nrtp_pkg::ST_HDR_C : nrtp_pkg::ST_HUNT;
			end
			nrtp_pkg::ST_HDR_C: begin
				step_d = (rx_byte == nrtp_pkg::CH_C) ? nrtp_pkg::ST_COMMA : nrtp_pkg::ST_HUNT;
			end
			nrtp_pkg::ST_COMMA: begin
				cnt_d  = '0;
				step_d = (rx_byte == nrtp_pkg::CH_COMMA) ? nrtp_pkg::ST_TIME
					: nrtp_pkg::ST_HUNT;
			end
			nrtp_pkg::ST_TIME: begin
				if (rx_byte == nrtp_pkg::CH_COMMA) begin
					if (cnt_q > nrtp_pkg::CNT_W'(7)) begin
						nib_d[0] = hour.tens;
						nib_d[1] = hour.ones;
					end
					cnt_d  = '0;
					step_d = nrtp_pkg::ST_VALID;
				end else if (cnt_q < nrtp_pkg::CNT_W'(nrtp_pkg::FIELD_LIMIT)) begin
					if (cnt_q < nrtp_pkg::CNT_W'(4)) begin
						nib_d[cnt_q[1:0]] = rx_byte[3:0];
					end
					cnt_d = cnt_q + nrtp_pkg::CNT_W'(1);
				end
			end
			nrtp_pkg::ST_VALID, nrtp_pkg::ST_SKIP: begin
				if (step_q == nrtp_pkg::ST_VALID) begin
					fix_valid_d = (rx_byte == nrtp_pkg::CH_A);
					step_d      = nrtp_pkg::ST_SKIP;
				end
				if (rx_byte == nrtp_pkg::CH_STAR) begin
					saved_xor_d = run_xor_d;
					step_d      = nrtp_pkg::ST_CK_HI;
				end
			end
			nrtp_pkg::ST_CK_HI: begin
				recv_xor_d = {nrtp_pkg::hex_nibble(rx_byte), 4'b0};
				step_d     = nrtp_pkg::ST_CK_LO;
			end
			nrtp_pkg::ST_CK_LO: begin
				recv_xor_d = recv_full;
				res_valid  = (saved_xor_q == recv_full);
				for (int i = 0; i < 4; i++) begin
					nib_d[i] = '0;
				end
				step_d = nrtp_pkg::ST_HUNT;
			end
			default: begin
				step_d = nrtp_pkg::ST_HUNT;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/nmea_rmc_time_parser.sv
// $GPRMC time parser, one received character per transaction.
// Input stream: s_tvalid/s_tready/s_tdata, s_tdata[7:0] = rx_byte.
// Output stream: one transaction per sentence whose checksum matches,
// carrying the four display digit codes and the no-fix flag.
// Configuration: cfg_we writes cfg_wdata into tz_offset (hours subtracted
// from the 12-hour folded UTC hour); write only while the block is idle.
// Throughput: one character per cycle while no result waits for m_tready.
// Result path: a character whose checksum digit completes a sentence is
// held in the input register; then the parser state and the result register
// update in a single pass and m_tvalid rises, unless a stall holds it first.
// Stall: the result register holds while m_tready is low; the input register
// keeps taking characters that give no result, and s_tready drops only when
// a finished result would otherwise be overwritten.
// Reset: arst_n clears the parser to hunting for '$', clears checksums,
// stored digits, tz_offset and both valid flags.
`default_nettype none

module nmea_rmc_time_parser (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [7:0]                     s_tdata,  // [7:0] rx_byte
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [3:0] tens_hour_code, [7:4] ones_hour, [11:8] tens_minute,
	// [15:12] ones_minute, [16] no_fix, rest zero
	output logic [nrtp_pkg::TDATA_W-1:0]        m_tdata,
	input  wire logic                           cfg_we,
	input  wire logic [3:0]                     cfg_wdata
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic [3:0]           tz_offset_q;
	logic                 res_valid;
	nrtp_pkg::result_t    res;
	nrtp_pkg::result_t    res_q;
	logic                 advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready || !res_valid);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_offset_q <= '0;
		end else if (cfg_we) begin
			tz_offset_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	nrtp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.rx_byte   (byte_s1),
		.tz_offset (tz_offset_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance && res_valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign m_tdata = {{(nrtp_pkg::TDATA_W - nrtp_pkg::RES_W){1'b0}}, res_q};

endmodule

`default_nettype wire

// File: sim/nmea_rmc_time_parser_test.sv
`timescale 1ns / 100ps

module nmea_rmc_time_parser_test;

	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_CHARS = 750;
	localparam int MIN_RESULTS  = 4;

	typedef enum int {CK_UPPER, CK_LOWER, CK_WRONG, CK_JUNK} ck_kind_t;

	class rmc_time_scoreboard;
		nrtp_pkg::step_t   step;
		int unsigned       n_field;
		logic [7:0]        run_xor;
		logic [7:0]        ck_saved;
		logic [7:0]        ck_got;
		logic              fix;
		logic [3:0]        nib [4];
		logic [3:0]        tz_hours;
		nrtp_pkg::result_t due_q [$];
		int                errors;
		int                n_chars_seen;
		int                n_due;
		int                n_checked;

		function new();
			step         = nrtp_pkg::ST_HUNT;
			n_field      = 0;
			run_xor      = '0;
			ck_saved     = '0;
			ck_got       = '0;
			fix          = 1'b0;
			tz_hours     = '0;
			errors       = 0;
			n_chars_seen = 0;
			n_due        = 0;
			n_checked    = 0;
			foreach (nib[i]) nib[i] = '0;
		endfunction

		function logic [3:0] hex_value(logic [7:0] c);
			logic [7:0] v;
			v = (c > nrtp_pkg::HEX_DIGIT_MAX) ? c - nrtp_pkg::HEX_ALPHA_BIAS : c;
			return v[3:0];
		endfunction

		function void note_byte(logic [7:0] b);
			int unsigned       h;
			nrtp_pkg::result_t r;
			n_chars_seen++;
			if (b != nrtp_pkg::CH_STAR) run_xor = run_xor ^ b;
			case (step)
				nrtp_pkg::ST_HUNT: begin
					step    = (b == nrtp_pkg::CH_DOLLAR) ? nrtp_pkg::ST_HDR_G
						: nrtp_pkg::ST_HUNT;
					run_xor = '0;
				end
				nrtp_pkg::ST_HDR_G:
					step = (b == nrtp_pkg::CH_G) ? nrtp_pkg::ST_HDR_P : nrtp_pkg::ST_HUNT;
				nrtp_pkg::ST_HDR_P:
					step = (b == nrtp_pkg::CH_P) ? nrtp_pkg::ST_HDR_R : nrtp_pkg::ST_HUNT;
				nrtp_pkg::ST_HDR_R:
					step = (b == nrtp_pkg::CH_R) ? nrtp_pkg::ST_HDR_M : nrtp_pkg::ST_HUNT;
				nrtp_pkg::ST_HDR_M:
					step = (b == nrtp_pkg::CH_M) ? nrtp_pkg::ST_HDR_C : nrtp_pkg::ST_HUNT;
				nrtp_pkg::ST_HDR_C:
					step = (b == nrtp_pkg::CH_C) ? nrtp_pkg::ST_COMMA : nrtp_pkg::ST_HUNT;
				nrtp_pkg::ST_COMMA: begin
					n_field = 0;
					step    = (b == nrtp_pkg::CH_COMMA) ? nrtp_pkg::ST_TIME
						: nrtp_pkg::ST_HUNT;
				end
				nrtp_pkg::ST_TIME: begin
					if (b == nrtp_pkg::CH_COMMA) begin
						if (n_field > 7) begin
							// fold to 12-hour, shift by offset; wrap counts as above nine
							h = int'(nib[0]) * 10 + int'(nib[1]);
							if (h > 12) h = h - 12;
							if (h <= tz_hours) h = h + 12;
							h = h - tz_hours;
							if (h > 9) begin
								nib[0] = 4'd1;
								h      = h - 10;
							end else begin
								nib[0] = 4'd0;
							end
							nib[1] = h[3:0];
						end
						n_field = 0;
						step    = nrtp_pkg::ST_VALID;
					end else if (n_field < nrtp_pkg::FIELD_LIMIT) begin
						if (n_field < 4) nib[n_field] = b[3:0];
						n_field++;
					end
				end
				nrtp_pkg::ST_VALID, nrtp_pkg::ST_SKIP: begin
					if (step == nrtp_pkg::ST_VALID) begin
						fix  = (b == nrtp_pkg::CH_A);
						step = nrtp_pkg::ST_SKIP;
					end
					if (b == nrtp_pkg::CH_STAR) begin
						ck_saved = run_xor;
						step     = nrtp_pkg::ST_CK_HI;
					end
				end
				nrtp_pkg::ST_CK_HI: begin
					ck_got = {hex_value(b), 4'h0};
					step   = nrtp_pkg::ST_CK_LO;
				end
				nrtp_pkg::ST_CK_LO: begin
					ck_got[3:0] = hex_value(b);
					if (ck_saved == ck_got) begin
						r.tens_hour_code = (nib[0] == 4'd1) ? nrtp_pkg::CODE_ONE
							: nrtp_pkg::CODE_BLANK;
						r.ones_hour      = nib[1];
						r.tens_minute    = nib[2];
						r.ones_minute    = nib[3];
						r.no_fix         = !fix;
						due_q.push_back(r);
						n_due++;
					end
					foreach (nib[i]) nib[i] = '0;
					step = nrtp_pkg::ST_HUNT;
				end
				default: step = nrtp_pkg::ST_HUNT;
			endcase
		endfunction

		function void check_result(logic [nrtp_pkg::TDATA_W-1:0] d);
			nrtp_pkg::result_t got;
			nrtp_pkg::result_t want;
			got = d[nrtp_pkg::RES_W-1:0];
			if (due_q.size() == 0) begin
				$error("unexpected time result %h", d);
				errors++;
				return;
			end
			want = due_q.pop_front();
			n_checked++;
			if (got.tens_hour_code !== want.tens_hour_code) begin
				$error("tens_hour_code: expected %0d, got %0d", want.tens_hour_code,
					got.tens_hour_code);
				errors++;
			end
			if (got.ones_hour !== want.ones_hour) begin
				$error("ones_hour: expected %0d, got %0d", want.ones_hour, got.ones_hour);
				errors++;
			end
			if (got.tens_minute !== want.tens_minute) begin
				$error("tens_minute: expected %0d, got %0d", want.tens_minute, got.tens_minute);
				errors++;
			end
			if (got.ones_minute !== want.ones_minute) begin
				$error("ones_minute: expected %0d, got %0d", want.ones_minute, got.ones_minute);
				errors++;
			end
			if (got.no_fix !== want.no_fix) begin
				$error("no_fix: expected %0d, got %0d", want.no_fix, got.no_fix);
				errors++;
			end
			if (d[nrtp_pkg::TDATA_W-1:nrtp_pkg::RES_W] !== '0) begin
				$error("tdata padding: expected 0, got %h",
					d[nrtp_pkg::TDATA_W-1:nrtp_pkg::RES_W]);
				errors++;
			end
		endfunction
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [7:0]                   s_tdata;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [nrtp_pkg::TDATA_W-1:0] m_tdata;
	logic                         cfg_we;
	logic [3:0]                   cfg_wdata;

	rmc_time_scoreboard sb = new;

	bit         idle_on = 1'b1;
	bit         tx_gaps;
	bit         hold_req;
	int         cyc;
	int         n_tz_writes;
	int         n_sentences;
	logic [7:0] ck_acc;
	logic [7:0] tx_q [$];
	logic [7:0] fld_q [$];
	logic [7:0] rest_q [$];

	nmea_rmc_time_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
			sb.check_result(m_tdata);
	end

	// receiver: random stall bursts, calm stretches, one long hold-off
	initial begin : rx_side
		int n;
		int calm_left;
		bit calm;
		calm_left = 100;
		calm      = 1'b0;
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			if (calm_left == 0) begin
				calm      = !calm;
				calm_left = $urandom_range(20, 200);
			end else begin
				calm_left--;
			end
			if (hold_req) begin
				m_tready <= 1'b0;
				for (n = 1; n < HOLD_CYCLES; n++) @(negedge clk);
				hold_req = 1'b0;
			end else if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
		if (v < 4'd10) return 8'h30 + v;
		return (lower ? 8'h61 : 8'h41) + v - 8'd10;
	endfunction

	task automatic send_byte(logic [7:0] b);
		@(negedge clk);
		if (idle_on && tx_gaps && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_byte(b);
	endtask

	task automatic flush_tx();
		while (tx_q.size() != 0) send_byte(tx_q.pop_front());
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.due_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_tz(logic [3:0] v);
		wait_idle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.tz_hours = v;
		n_tz_writes++;
	endtask

	task automatic push_ck(logic [7:0] c);
		tx_q.push_back(c);
		if (c != nrtp_pkg::CH_STAR) ck_acc = ck_acc ^ c;
	endtask

	task automatic load_text(string s, bit into_rest);
		int i;
		if (into_rest) rest_q = {};
		else fld_q = {};
		for (i = 0; i < s.len(); i++) begin
			if (into_rest) rest_q.push_back(s[i]);
			else fld_q.push_back(s[i]);
		end
	endtask

	// sentence built from fld_q and rest_q; '*' as validity ends the body
	task automatic put_sentence(logic [7:0] vld, ck_kind_t kind);
		logic [7:0] w;
		ck_acc = '0;
		tx_q.push_back(nrtp_pkg::CH_DOLLAR);
		push_ck(nrtp_pkg::CH_G);
		push_ck(nrtp_pkg::CH_P);
		push_ck(nrtp_pkg::CH_R);
		push_ck(nrtp_pkg::CH_M);
		push_ck(nrtp_pkg::CH_C);
		push_ck(nrtp_pkg::CH_COMMA);
		foreach (fld_q[i]) push_ck(fld_q[i]);
		push_ck(nrtp_pkg::CH_COMMA);
		push_ck(vld);
		if (vld != nrtp_pkg::CH_STAR) begin
			foreach (rest_q[i]) push_ck(rest_q[i]);
			tx_q.push_back(nrtp_pkg::CH_STAR);
		end
		case (kind)
			CK_UPPER, CK_LOWER: begin
				tx_q.push_back(hex_char(ck_acc[7:4], kind == CK_LOWER));
				tx_q.push_back(hex_char(ck_acc[3:0], kind == CK_LOWER));
			end
			CK_WRONG: begin
				w = ck_acc ^ 8'($urandom_range(1, 255));
				tx_q.push_back(hex_char(w[7:4], 1'b0));
				tx_q.push_back(hex_char(w[3:0], 1'b0));
			end
			default: begin
				tx_q.push_back(8'($urandom_range(0, 255)));
				tx_q.push_back(8'($urandom_range(0, 255)));
			end
		endcase
		n_sentences++;
	endtask

	task automatic rand_sentence();
		string      pool;
		int         len;
		int         hr;
		int         mn;
		int         i;
		int         r;
		bit         odd;
		logic [7:0] c;
		logic [7:0] v;
		ck_kind_t   kind;
		pool = ",.0123456789NSEW";
		r    = $urandom_range(0, 99);
		len  = (r < 70) ? $urandom_range(8, 10) :
		       (r < 85) ? $urandom_range(0, 7) : $urandom_range(11, 20);
		hr   = $urandom_range(0, 23);
		mn   = $urandom_range(0, 59);
		odd  = ($urandom_range(0, 9) == 0);
		fld_q = {};
		for (i = 0; i < len; i++) begin
			case (i)
				0:       c = 8'h30 + 8'(hr / 10);
				1:       c = 8'h30 + 8'(hr % 10);
				2:       c = 8'h30 + 8'(mn / 10);
				3:       c = 8'h30 + 8'(mn % 10);
				6:       c = 8'h2E;
				default: c = 8'h30 + 8'($urandom_range(0, 9));
			endcase
			if (odd && $urandom_range(0, 2) == 0) c = 8'($urandom_range(0, 255));
			if (c == nrtp_pkg::CH_COMMA) c = 8'h3A;
			fld_q.push_back(c);
		end
		rest_q = {};
		repeat ($urandom_range(0, 6)) rest_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
		r = $urandom_range(0, 99);
		v = (r < 60) ? nrtp_pkg::CH_A : (r < 90) ? 8'h56 : (r < 95) ? nrtp_pkg::CH_STAR
			: 8'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		kind = (r < 45) ? CK_UPPER : (r < 85) ? CK_LOWER : (r < 95) ? CK_WRONG : CK_JUNK;
		put_sentence(v, kind);
	endtask

	initial begin : main_seq
		logic [7:0] hdr [0:6];
		logic [7:0] c;
		int         ph;
		int         r;
		int         pos;
		int         i;
		int         start;
		int         due0;
		hdr = '{nrtp_pkg::CH_DOLLAR, nrtp_pkg::CH_G, nrtp_pkg::CH_P, nrtp_pkg::CH_R,
			nrtp_pkg::CH_M, nrtp_pkg::CH_C, nrtp_pkg::CH_COMMA};
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		hold_req  = 1'b0;
		tx_gaps   = 1'b1;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		write_tz(4'd0);
		tx_q.push_back(8'h00);
		tx_q.push_back(8'hFF);
		load_text("", 1'b1);
		load_text("123456.00", 1'b0);
		put_sentence(nrtp_pkg::CH_A, CK_UPPER);
		// broken header, then a one-character time field without a fix
		tx_q.push_back(nrtp_pkg::CH_DOLLAR);
		tx_q.push_back(nrtp_pkg::CH_G);
		tx_q.push_back(nrtp_pkg::CH_P);
		tx_q.push_back(nrtp_pkg::CH_R);
		tx_q.push_back(nrtp_pkg::CH_M);
		tx_q.push_back(8'h58);
		load_text("0", 1'b0);
		load_text(",1.5", 1'b1);
		put_sentence(8'h56, CK_LOWER);
		load_text("", 1'b1);
		load_text("235959.0123456789AB", 1'b0);
		put_sentence(nrtp_pkg::CH_A, CK_UPPER);
		load_text(":?;=.5.7", 1'b0);
		put_sentence(8'h56, CK_UPPER);
		load_text("0930", 1'b0);
		put_sentence(nrtp_pkg::CH_STAR, CK_UPPER);
		load_text("0000000", 1'b0);
		put_sentence(nrtp_pkg::CH_A, CK_WRONG);
		load_text("1200000", 1'b0);
		put_sentence(nrtp_pkg::CH_A, CK_JUNK);
		flush_tx();

		write_tz(4'd15);
		load_text("000000.00", 1'b0);
		put_sentence(nrtp_pkg::CH_A, CK_UPPER);
		load_text("130000.00", 1'b0);
		put_sentence(nrtp_pkg::CH_A, CK_UPPER);
		flush_tx();
		write_tz(4'd13);
		load_text("120000.0", 1'b0);
		put_sentence(nrtp_pkg::CH_A, CK_LOWER);
		flush_tx();
		write_tz(4'd12);
		load_text("000000.00", 1'b0);
		put_sentence(nrtp_pkg::CH_A, CK_UPPER);
		load_text("235900.00", 1'b0);
		put_sentence(8'h56, CK_UPPER);
		flush_tx();

		for (ph = 0; ph < 5; ph++) begin
			case (ph)
				0:       write_tz(4'($urandom_range(1, 11)));
				1:       write_tz(4'd12);
				2:       write_tz(4'd0);
				default: write_tz(4'($urandom_range(0, 12)));
			endcase
			if (ph == 1) hold_req = 1'b1;
			if (ph == 4) idle_on = 1'b0;
			start = sb.n_chars_seen;
			due0  = sb.n_due;
			while (sb.n_chars_seen - start < RANDOM_CHARS / 5 ||
			       (ph == 4 && sb.n_due - due0 < MIN_RESULTS)) begin
				tx_gaps = ($urandom_range(0, 9) < 7);
				r = $urandom_range(0, 99);
				if (r < 80) begin
					rand_sentence();
				end else if (r < 88) begin
					pos = $urandom_range(1, 6);
					for (i = 0; i < pos; i++) tx_q.push_back(hdr[i]);
					c = 8'($urandom_range(0, 255));
					if (c == hdr[pos]) c = c ^ 8'h01;
					tx_q.push_back(c);
					repeat ($urandom_range(0, 5)) tx_q.push_back(8'($urandom_range(0, 255)));
				end else if (r < 94) begin
					repeat ($urandom_range(1, 8)) tx_q.push_back(8'($urandom_range(0, 255)));
				end else begin
					rand_sentence();
					pos = $urandom_range(1, tx_q.size() - 1);
					while (tx_q.size() > pos) void'(tx_q.pop_back());
				end
				flush_tx();
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		$display("%0d characters sent, %0d sentences built, %0d offset writes",
			sb.n_chars_seen, n_sentences, n_tz_writes);
		$display("offsets 0, 12, 13, 15 used; %0d time results checked; hold-off %0d cycles",
			sb.n_checked, HOLD_CYCLES);
		if (sb.errors == 0 && sb.due_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
